@@ design/bsq_pkg.sv @@
// ----------------------------------------------------------------------------
// bsq_pkg - shared definitions for the bounded stable priority queue
// Holds the default sizes, the field widths and the control struct
// that the top level hands to every cell of the chain.
// ----------------------------------------------------------------------------
package bsq_pkg;

  localparam int DefMaxEntries = 16;
  localparam int DefTagBits    = 16;

  localparam int PrioW  = 32;
  localparam int TagW   = 16;
  localparam int CountW = 5;
  localparam int CapW   = 5;
  localparam logic [CapW-1:0] CapReset = CapW'(16);

  localparam logic CmdAdd      = 1'b0;
  localparam logic CmdComplete = 1'b1;

  // Control for one chain update.
  typedef struct packed {
    logic ins;   // accepted add: sorted insertion
    logic rem;   // accepted complete: every cell takes its successor
  } cell_op_t;

endpackage

@@ design/bsq_cell.sv @@
// ----------------------------------------------------------------------------
// bsq_cell - one slot of the sorted entry chain
// Holds one entry and, on an insertion, keeps it, takes the new entry or
// takes its predecessor's; on a removal it takes its successor's entry.
// ----------------------------------------------------------------------------
module bsq_cell #(
  parameter int TAG_BITS = bsq_pkg::DefTagBits
) (
  input  logic                          clk,
  input  bsq_pkg::cell_op_t             op,
  input  logic                          occupied,
  input  logic signed [bsq_pkg::PrioW-1:0] new_prio,
  input  logic [TAG_BITS-1:0]           new_tag,
  input  logic                          prev_keep,
  input  logic signed [bsq_pkg::PrioW-1:0] prev_prio,
  input  logic [TAG_BITS-1:0]           prev_tag,
  input  logic signed [bsq_pkg::PrioW-1:0] next_prio,
  input  logic [TAG_BITS-1:0]           next_tag,
  output logic                          keep,
  output logic signed [bsq_pkg::PrioW-1:0] prio,
  output logic [TAG_BITS-1:0]           tag
);

  logic signed [bsq_pkg::PrioW-1:0] prio_r, prio_nxt;
  logic [TAG_BITS-1:0]              tag_r, tag_nxt;

  // An entry of equal priority stays ahead of the new one, which keeps
  // insertion order among equals.
  assign keep = occupied && (prio_r >= new_prio);

  always_comb begin
    prio_nxt = prio_r;
    tag_nxt  = tag_r;
    if (op.ins && !keep) begin
      if (prev_keep) begin
        prio_nxt = new_prio;
        tag_nxt  = new_tag;
      end else begin
        prio_nxt = prev_prio;
        tag_nxt  = prev_tag;
      end
    end else if (op.rem) begin
      prio_nxt = next_prio;
      tag_nxt  = next_tag;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    tag_r  <= tag_nxt;
  end

  assign prio = prio_r;
  assign tag  = tag_r;

endmodule

@@ design/bounded_stable_priority_queue.sv @@
// ----------------------------------------------------------------------------
// bounded_stable_priority_queue - bounded max-priority queue, FIFO among ties
// A chain of cells kept in service order; adds are sorted in, completes
// shift the whole chain up by one.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one command per beat: in_tuser is the command
//   (0 add, 1 complete) and in_tdata the priority and tag of an add. The
//   result channel returns exactly one beat per command with the acceptance
//   flag, the new count and the entry that would be served next.
//   The user writes the capacity register via cfg_wr_en/cfg_wr_data while the
//   block is idle (unenforced); values above MAX_ENTRIES act as MAX_ENTRIES.
// Result timing:
//   The chain updates at the edge that accepts a command; the result is
//   registered on the following edge if the output register is free.
//   One command is in flight at a time: the chain update is followed by
//   the read of its head cell, and only then is the next command taken.
// Reset and stalls:
//   Reset empties the queue, drops any pending result and restores the
//   capacity to 16. While the receiver holds out_tready low the result waits
//   in the output register; at most one further command is taken, and its
//   result waits until the output register is free.
// ----------------------------------------------------------------------------
module bounded_stable_priority_queue #(
  parameter int MAX_ENTRIES = bsq_pkg::DefMaxEntries,
  parameter int TAG_BITS    = bsq_pkg::DefTagBits
) (
  input  logic        clk,
  input  logic        rst_n,
  // Command channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] priority_req, [47:32] task_tag
  input  logic        in_tuser,   // [0] cmd
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] accepted, [5:1] entry_count, [6] top_valid, [38:7] top_priority,
  // [54:39] top_tag, [55] zero
  output logic [55:0] out_tdata,
  // Configuration
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);

  localparam int CntW  = $clog2(MAX_ENTRIES + 1);
  localparam int CmpW  = (CntW > bsq_pkg::CapW) ? CntW : bsq_pkg::CapW;
  localparam int WideW = (TAG_BITS > bsq_pkg::TagW) ? TAG_BITS : bsq_pkg::TagW;
  localparam int OutW  = 1 + bsq_pkg::CountW + 1 + bsq_pkg::PrioW + bsq_pkg::TagW;

  // Configuration register.
  logic [bsq_pkg::CapW-1:0] cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= bsq_pkg::CapReset;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // Command decode.
  logic                             in_beat;
  logic                             cmd;
  logic signed [bsq_pkg::PrioW-1:0] new_prio;
  logic [WideW-1:0]                 new_tag_wide;
  logic [TAG_BITS-1:0]              new_tag;
  logic [CntW-1:0]                  count_r, count_nxt;
  logic [CmpW-1:0]                  limit;
  logic                             can_add, can_rem;
  logic                             ok;
  bsq_pkg::cell_op_t                op;
  logic                             pending_r, acc_r;

  assign in_tready    = !pending_r;
  assign in_beat      = in_tvalid && in_tready;
  assign cmd          = in_tuser;
  assign new_prio     = in_tdata[31:0];
  assign new_tag_wide = WideW'(in_tdata[47:32]);
  assign new_tag      = new_tag_wide[TAG_BITS-1:0];

  // The effective capacity saturates at the chain length.
  assign limit   = (CmpW'(cap_r) > CmpW'(MAX_ENTRIES)) ? CmpW'(MAX_ENTRIES)
                                                       : CmpW'(cap_r);
  assign can_add = CmpW'(count_r) < limit;
  assign can_rem = count_r != '0;
  assign ok      = (cmd == bsq_pkg::CmdAdd) ? can_add : can_rem;

  assign op.ins = in_beat && (cmd == bsq_pkg::CmdAdd) && can_add;
  assign op.rem = in_beat && (cmd == bsq_pkg::CmdComplete) && can_rem;

  always_comb begin
    count_nxt = count_r;
    if (op.ins) begin
      count_nxt = count_r + CntW'(1);
    end else if (op.rem) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Cell chain. Cell 0 is always the entry to be served next.
  logic                             keep [MAX_ENTRIES];
  logic signed [bsq_pkg::PrioW-1:0] prio [MAX_ENTRIES];
  logic [TAG_BITS-1:0]              tag  [MAX_ENTRIES];

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic                             p_keep;
    logic signed [bsq_pkg::PrioW-1:0] p_prio, n_prio;
    logic [TAG_BITS-1:0]              p_tag, n_tag;
    logic                             occ;

    assign occ = CntW'(i) < count_r;

    if (i == 0) begin : g_head
      // On an insertion the head takes the new entry whenever it does not keep its own.
      assign p_keep = 1'b1;
      assign p_prio = new_prio;
      assign p_tag  = new_tag;
    end else begin : g_body
      assign p_keep = keep[i-1];
      assign p_prio = prio[i-1];
      assign p_tag  = tag[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      // Past the last cell nothing is held; its content after a removal is
      // beyond the count and never read.
      assign n_prio = prio[i];
      assign n_tag  = tag[i];
    end else begin : g_inner
      assign n_prio = prio[i+1];
      assign n_tag  = tag[i+1];
    end

    bsq_cell #(
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .occupied  (occ),
      .new_prio  (new_prio),
      .new_tag   (new_tag),
      .prev_keep (p_keep),
      .prev_prio (p_prio),
      .prev_tag  (p_tag),
      .next_prio (n_prio),
      .next_tag  (n_tag),
      .keep      (keep[i]),
      .prio      (prio[i]),
      .tag       (tag[i])
    );
  end

  // Result staging: the chain settles at the accepting edge, and the head
  // is read into the output register on a later edge.
  logic             out_load;
  logic             out_valid_r;
  logic [55:0]      out_data_r, out_data_nxt;
  logic             top_valid;
  logic [WideW-1:0] head_tag_wide;
  logic [bsq_pkg::CountW-1:0] count_out;
  logic [CmpW-1:0]  count_cmp;

  assign out_load      = pending_r && (!out_valid_r || out_tready);
  assign top_valid     = count_r != '0;
  assign head_tag_wide = WideW'(tag[0]);
  assign count_cmp     = CmpW'(count_r);
  assign count_out     = count_cmp[bsq_pkg::CountW-1:0];

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[OutW-1:0] = {
      top_valid ? head_tag_wide[bsq_pkg::TagW-1:0] : {bsq_pkg::TagW{1'b0}},
      top_valid ? prio[0] : {bsq_pkg::PrioW{1'b0}},
      top_valid,
      count_out,
      acc_r
    };
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_beat) begin
        pending_r <= 1'b1;
      end else if (out_load) begin
        pending_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      acc_r <= ok;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ design/bsq_checker.sv @@
// ----------------------------------------------------------------------------
// bsq_checker - port-level checks for the bounded stable priority queue
// Watches the top level's ports and flags results that are inconsistent
// in themselves or over time.
// ----------------------------------------------------------------------------
module bsq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  // One command at a time: no beat is taken directly after another.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("command taken while another is in flight");

  // The top entry is valid exactly when the queue holds something.
  a_top_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[6] == (out_tdata[5:1] != 5'd0)))
    else $error("top_valid disagrees with entry_count");

  // An empty queue reports zero top fields.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[6]) |-> (out_tdata[54:7] == 48'd0))
    else $error("empty queue reports a non-zero top entry");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result beat changed");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat present after reset");

endmodule

bind bounded_stable_priority_queue bsq_checker u_bsq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - bounded stable priority queue
// Drives add and complete commands through the command stream and tracks the
// queue contents in a scoreboard. Every result beat is checked field by field
// against the status the tracker expects: acceptance, count and the top entry.
// ----------------------------------------------------------------------------
module testbench;

  localparam int QueueDepth = bsq_pkg::DefMaxEntries;

  // Handshake pressure applied by the driving and receiving processes.
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // One result beat, decoded into its fields.
  typedef struct packed {
    logic                             accepted;
    logic [bsq_pkg::CountW-1:0]       count;
    logic                             top_valid;
    logic signed [bsq_pkg::PrioW-1:0] top_prio;
    logic [bsq_pkg::TagW-1:0]         top_tag;
  } queue_status_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the queue in insertion order, works out
  // the status beat that every command must produce and checks the
  // beats that come back in order.
  // --------------------------------------------------------------------------
  class queue_scoreboard;
    logic signed [bsq_pkg::PrioW-1:0] slot_prio [QueueDepth];
    logic [bsq_pkg::TagW-1:0]         slot_tag  [QueueDepth];
    int                               held;
    logic [bsq_pkg::CapW-1:0]         capacity;
    queue_status_t                    pending_status[$];
    int                               mismatches;

    function new();
      held       = 0;
      capacity   = bsq_pkg::CapReset;
      mismatches = 0;
    endfunction

    function void set_capacity(logic [bsq_pkg::CapW-1:0] value);
      capacity = value;
    endfunction

    function int pending_count();
      return pending_status.size();
    endfunction

    // First slot holding the strictly largest priority, so ties go out in
    // the order they came in.
    function int top_slot();
      int best;
      best = 0;
      for (int i = 1; i < held; i++) begin
        if (slot_prio[i] > slot_prio[best]) best = i;
      end
      return best;
    endfunction

    function void note_command(logic cmd, logic signed [bsq_pkg::PrioW-1:0] prio,
                               logic [bsq_pkg::TagW-1:0] tag);
      int            limit;
      int            k;
      queue_status_t st;
      limit = (capacity > QueueDepth) ? QueueDepth : int'(capacity);
      st = '0;
      if (cmd == bsq_pkg::CmdAdd) begin
        if (held < limit) begin
          slot_prio[held] = prio;
          slot_tag[held]  = tag;
          held++;
          st.accepted = 1'b1;
        end
      end else if (held > 0) begin
        k = top_slot();
        for (int i = k; i + 1 < held; i++) begin
          slot_prio[i] = slot_prio[i + 1];
          slot_tag[i]  = slot_tag[i + 1];
        end
        held--;
        st.accepted = 1'b1;
      end
      st.count = bsq_pkg::CountW'(held);
      if (held > 0) begin
        k = top_slot();
        st.top_valid = 1'b1;
        st.top_prio  = slot_prio[k];
        st.top_tag   = slot_tag[k];
      end
      pending_status.push_back(st);
    endfunction

    function void check_result(logic [55:0] beat);
      queue_status_t got;
      queue_status_t want;
      got.accepted  = beat[0];
      got.count     = beat[5:1];
      got.top_valid = beat[6];
      got.top_prio  = beat[38:7];
      got.top_tag   = beat[54:39];
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat with nothing outstanding: acc=%0b cnt=%0d", got.accepted,
                   got.count);
        return;
      end
      want = pending_status.pop_front();
      if (got.accepted !== want.accepted || got.count !== want.count ||
          got.top_valid !== want.top_valid || got.top_prio !== want.top_prio ||
          got.top_tag !== want.top_tag) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected acc=%0b cnt=%0d vld=%0b prio=%0d tag=%h",
                   want.accepted, want.count, want.top_valid, want.top_prio,
                   want.top_tag);
          $display("          got      acc=%0b cnt=%0d vld=%0b prio=%0d tag=%h",
                   got.accepted, got.count, got.top_valid, got.top_prio,
                   got.top_tag);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;    // [31:0] priority_req, [47:32] task_tag
  logic        in_tuser;    // [0] cmd
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;   // [0] accepted, [5:1] entry_count, [6] top_valid,
                            // [38:7] top_priority, [54:39] top_tag, [55] zero
  logic        cfg_wr_en;
  logic [4:0]  cfg_wr_data;

  queue_scoreboard sb;
  idle_mode_t      idle_mode;
  bit              hold_trigger;

  bounded_stable_priority_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop. The slowest legitimate run (every beat waiting out the longest
  // sender gap and a long receiver stall, plus the long hold-off) stays well
  // inside this.
  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

  // Receiver side. It stalls at random according to the current idle mode,
  // and when asked it holds off for a long, counted stretch so that the
  // result register and the command slot behind it both fill and the block
  // has to stall its command channel.
  initial begin
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_trigger) begin
        hold_trigger = 1'b0;
        hold_left    = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (idle_mode == IDLE_RECEIVER) begin
        out_tready <= ($urandom_range(99) >= 63);
      end else if (idle_mode == IDLE_BOTH) begin
        out_tready <= ($urandom_range(99) >= 31);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Result beats are taken at the rising edge and checked in order.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Offers one command beat, preceded by a random gap when the sender idles.
  // tvalid is left high after acceptance so back-to-back beats never see it
  // dropped and raised within the same step.
  task automatic send_command(input logic cmd,
                              input logic signed [bsq_pkg::PrioW-1:0] prio,
                              input logic [bsq_pkg::TagW-1:0] tag);
    int gap;
    int pct;
    gap = 0;
    pct = (idle_mode == IDLE_SENDER) ? 63 : (idle_mode == IDLE_BOTH) ? 31 : 0;
    while (gap < 40 && $urandom_range(99) < pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {tag, prio};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    sb.note_command(cmd, prio, tag);
  endtask

  // Stops offering and waits until every outstanding status beat is back,
  // then a few more cycles so the block is certainly idle.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Capacity writes happen only while the block is idle.
  task automatic write_capacity(input logic [bsq_pkg::CapW-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_capacity(value);
  endtask

  // Random priority: mostly a narrow band so that ties are common, with
  // full-range values and the extremes mixed in.
  function automatic logic signed [bsq_pkg::PrioW-1:0] pick_priority();
    int kind;
    kind = $urandom_range(9);
    if (kind < 5) return bsq_pkg::PrioW'($signed($urandom_range(4)) - 2);
    if (kind < 8) return $urandom;
    case ($urandom_range(3))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      default: return -1;
    endcase
  endfunction

  initial begin
    // Each random phase: capacity, idle mode, share of adds in percent and
    // number of commands. The queue is not emptied between phases, so a
    // lower capacity often lands below the current count.
    int         caps[9]   = '{16, 3, 31, 0, 17, 1, 8, 16, 5};
    idle_mode_t modes[9]  = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                              IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                              IDLE_NONE};
    int         adds[9]   = '{70, 50, 60, 40, 55, 50, 50, 55, 50};
    int         counts[9] = '{120, 100, 130, 80, 80, 80, 120, 120, 100};
    logic       cmd;

    sb           = new();
    idle_mode    = IDLE_NONE;
    hold_trigger = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = bsq_pkg::CmdAdd;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: complete on an empty queue, both priority extremes, ties at
    // zero and at the maximum (served in arrival order), then drain to empty
    // and one refused complete beyond that.
    send_command(bsq_pkg::CmdComplete, 32'sd0, 16'h0000);
    send_command(bsq_pkg::CmdAdd, 32'sh8000_0000, 16'h0000);
    send_command(bsq_pkg::CmdAdd, 32'sh7fff_ffff, 16'hffff);
    send_command(bsq_pkg::CmdAdd, 32'sd0, 16'h0001);
    send_command(bsq_pkg::CmdAdd, 32'sd0, 16'h0002);
    send_command(bsq_pkg::CmdAdd, -32'sd1, 16'haaaa);
    send_command(bsq_pkg::CmdAdd, 32'sh7fff_ffff, 16'h5555);
    repeat (7) send_command(bsq_pkg::CmdComplete, 32'sh7fff_ffff, 16'hffff);

    // Zero capacity refuses every add.
    write_capacity(5'd0);
    send_command(bsq_pkg::CmdAdd, 32'sd7, 16'h1234);
    send_command(bsq_pkg::CmdAdd, -32'sd7, 16'hedcb);
    send_command(bsq_pkg::CmdComplete, 32'sd0, 16'h0000);

    // Capacity of one: the second add is refused.
    write_capacity(5'd1);
    send_command(bsq_pkg::CmdAdd, 32'sd3, 16'h00ff);
    send_command(bsq_pkg::CmdAdd, 32'sd9, 16'hff00);
    send_command(bsq_pkg::CmdComplete, 32'sd0, 16'h0000);

    for (int p = 0; p < 9; p++) begin
      write_capacity(bsq_pkg::CapW'(caps[p]));
      idle_mode = modes[p];
      // Long receiver hold-off while commands keep coming, in the first phase.
      if (p == 0) hold_trigger = 1'b1;
      for (int k = 0; k < counts[p]; k++) begin
        // Once, the sender stops mid-phase until every status beat is back.
        if (p == 4 && k == counts[p] / 2) drain_results();
        cmd = ($urandom_range(99) < adds[p]) ? bsq_pkg::CmdAdd : bsq_pkg::CmdComplete;
        send_command(cmd, pick_priority(), bsq_pkg::TagW'($urandom_range(65535)));
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
